FILE: rtl/core/sha1md_pkg.sv
//------------------------------------------------------------------------------
// SHA-1 message digest package
// Word types, round constants, initial chaining values and length limit.
//------------------------------------------------------------------------------
`default_nettype none

package sha1md_pkg;

	localparam int LENGTH_FIELD_BITS = 64;

	localparam logic [63:0] COUNT_LIMIT = (LENGTH_FIELD_BITS >= 64) ? {64{1'b1}} :
		((64'd1 << LENGTH_FIELD_BITS) - 64'd1);

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [31:0] H_INIT0 = 32'h67452301;
	localparam logic [31:0] H_INIT1 = 32'hEFCDAB89;
	localparam logic [31:0] H_INIT2 = 32'h98BADCFE;
	localparam logic [31:0] H_INIT3 = 32'h10325476;
	localparam logic [31:0] H_INIT4 = 32'hC3D2E1F0;

	localparam logic [7:0] PAD_MARK = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       end_of_message;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_number;
		logic        last_word;
	} dig_t;

endpackage

`default_nettype wire

FILE: rtl/core/sha1_message_digest_top.sv
//------------------------------------------------------------------------------
// SHA-1 message digest core
// Packs message bytes into a 512-bit block, runs the 80-round compression
// one round per cycle, pads on end of message and emits five digest words.
//------------------------------------------------------------------------------
//  channel  | signals                  | moves
//  msg      | msg_valid, msg_ready     | one message byte and/or end marker
//  dig      | dig_valid, dig_ready     | one digest word, H0 first
//
//  A byte word is written into the block as it is accepted. A full block adds
//  the 80 rounds and the chaining add on the single round adder. An end marker
//  adds one padding byte a cycle (9 to 72 bytes) plus one or two compressions,
//  then five digest words. msg_ready is low while padding, compressing, adding
//  or emitting. After the fifth digest word all control and chaining state returns to its reset values.
//------------------------------------------------------------------------------
`default_nettype none

module sha1_message_digest_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              msg_valid,
	output logic                   msg_ready,
	input  wire sha1md_pkg::msg_t  msg,
	output logic                   dig_valid,
	input  wire logic              dig_ready,
	output sha1md_pkg::dig_t       dig
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_PAD  = 5'b00010,
		ST_COMP = 5'b00100,
		ST_HADD = 5'b01000,
		ST_OUT  = 5'b10000
	} state_t;

	state_t            state_q;
	logic [5:0]        idx_q;
	logic [6:0]        round_q;
	logic [63:0]       count_q;
	logic              end_q;
	logic              done_q;
	logic              first_q;
	logic              len_q;
	logic [2:0]        wcnt_q;
	logic [31:0]       hash_q [5];

	logic [15:0][31:0] win_q;
	logic [31:0]       a_q, b_q, c_q, d_q, e_q;

	logic              msg_acc;
	logic              put_en;
	logic [7:0]        put_byte;
	logic [7:0]        len_byte;
	logic              block_full;
	logic [31:0]       rnd_f;
	logic [31:0]       rnd_k;
	logic [31:0]       rnd_t;
	logic [31:0]       sched_x;

	assign msg_ready = (state_q == ST_IDLE);
	assign msg_acc   = msg_valid && msg_ready;

	assign len_byte   = 8'(count_q >> {~idx_q[2:0], 3'b000});
	assign put_en     = (msg_acc && msg.byte_present) || (state_q == ST_PAD);
	assign block_full = put_en && (idx_q == 6'd63);

	always_comb begin
		if (state_q == ST_IDLE) begin
			put_byte = msg.data_byte;
		end else if (first_q) begin
			put_byte = sha1md_pkg::PAD_MARK;
		end else if (len_q || (idx_q == 6'd56)) begin
			put_byte = len_byte;
		end else begin
			put_byte = 8'h00;
		end
	end

	always_comb begin
		if (round_q < 7'd20) begin
			rnd_f = (b_q & c_q) | (~b_q & d_q);
			rnd_k = sha1md_pkg::K_R0;
		end else if (round_q < 7'd40) begin
			rnd_f = b_q ^ c_q ^ d_q;
			rnd_k = sha1md_pkg::K_R1;
		end else if (round_q < 7'd60) begin
			rnd_f = (b_q & c_q) | (b_q & d_q) | (c_q & d_q);
			rnd_k = sha1md_pkg::K_R2;
		end else begin
			rnd_f = b_q ^ c_q ^ d_q;
			rnd_k = sha1md_pkg::K_R3;
		end
	end

	assign rnd_t   = {a_q[26:0], a_q[31:27]} + rnd_f + e_q + win_q[15] + rnd_k;
	assign sched_x = win_q[2] ^ win_q[7] ^ win_q[13] ^ win_q[15];

	assign dig_valid = (state_q == ST_OUT);
	assign dig       = '{digest_word: hash_q[wcnt_q], word_number: wcnt_q,
		last_word: (wcnt_q == 3'd4)};

	// control and chaining state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			idx_q     <= '0;
			round_q   <= '0;
			count_q   <= '0;
			end_q     <= 1'b0;
			done_q    <= 1'b0;
			first_q   <= 1'b0;
			len_q     <= 1'b0;
			wcnt_q    <= '0;
			hash_q[0] <= sha1md_pkg::H_INIT0;
			hash_q[1] <= sha1md_pkg::H_INIT1;
			hash_q[2] <= sha1md_pkg::H_INIT2;
			hash_q[3] <= sha1md_pkg::H_INIT3;
			hash_q[4] <= sha1md_pkg::H_INIT4;
		end else begin
			if (put_en) begin
				idx_q <= idx_q + 6'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg.byte_present) begin
							if (count_q > sha1md_pkg::COUNT_LIMIT - 64'd8) begin
								count_q <= sha1md_pkg::COUNT_LIMIT;
							end else begin
								count_q <= count_q + 64'd8;
							end
						end
						if (msg.end_of_message) begin
							end_q   <= 1'b1;
							first_q <= 1'b1;
						end
						if (block_full) begin
							round_q <= '0;
							state_q <= ST_COMP;
						end else if (msg.end_of_message) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					first_q <= 1'b0;
					if (!first_q && (idx_q == 6'd56)) begin
						len_q <= 1'b1;
					end
					if (block_full) begin
						done_q  <= len_q;
						round_q <= '0;
						state_q <= ST_COMP;
					end
				end
				ST_COMP: begin
					round_q <= round_q + 7'd1;
					if (round_q == 7'd79) begin
						state_q <= ST_HADD;
					end
				end
				ST_HADD: begin
					hash_q[0] <= hash_q[0] + a_q;
					hash_q[1] <= hash_q[1] + b_q;
					hash_q[2] <= hash_q[2] + c_q;
					hash_q[3] <= hash_q[3] + d_q;
					hash_q[4] <= hash_q[4] + e_q;
					if (done_q) begin
						wcnt_q  <= '0;
						state_q <= ST_OUT;
					end else if (end_q) begin
						state_q <= ST_PAD;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_OUT: begin
					if (dig_ready) begin
						if (wcnt_q == 3'd4) begin
							// drop back to reset state for the next message
							state_q   <= ST_IDLE;
							idx_q     <= '0;
							round_q   <= '0;
							count_q   <= '0;
							end_q     <= 1'b0;
							done_q    <= 1'b0;
							first_q   <= 1'b0;
							len_q     <= 1'b0;
							wcnt_q    <= '0;
							hash_q[0] <= sha1md_pkg::H_INIT0;
							hash_q[1] <= sha1md_pkg::H_INIT1;
							hash_q[2] <= sha1md_pkg::H_INIT2;
							hash_q[3] <= sha1md_pkg::H_INIT3;
							hash_q[4] <= sha1md_pkg::H_INIT4;
						end else begin
							wcnt_q <= wcnt_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// block window and working variables
	always_ff @(posedge clk) begin
		if (put_en) begin
			win_q <= {win_q[15][23:0], win_q[14:0], put_byte};
		end else if (state_q == ST_COMP) begin
			win_q <= {win_q[14:0], {sched_x[30:0], sched_x[31]}};
		end
		if (block_full) begin
			a_q <= hash_q[0];
			b_q <= hash_q[1];
			c_q <= hash_q[2];
			d_q <= hash_q[3];
			e_q <= hash_q[4];
		end else if (state_q == ST_COMP) begin
			a_q <= rnd_t;
			b_q <= a_q;
			c_q <= {b_q[1:0], b_q[31:2]};
			d_q <= c_q;
			e_q <= d_q;
		end
	end

endmodule

`default_nettype wire

FILE: tb/sha1_digest_checker.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// SHA-1 digest checker
// Watches the message and digest channels, keeps its own SHA-1 state to
// work out the five digest words that each end of message produces, and
// compares every accepted digest word with the oldest one still due.
//------------------------------------------------------------------------------

module sha1_digest_checker (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                msg_valid,
	input  logic                msg_ready,
	input  sha1md_pkg::msg_t    msg,
	input  logic                dig_valid,
	input  logic                dig_ready,
	input  sha1md_pkg::dig_t    dig,
	output int                  fail_count,
	output int                  pending
);

	logic [31:0]      sched_w [16];
	logic [31:0]      chain_h [5];
	logic [63:0]      msg_bits;
	int               fill;
	sha1md_pkg::dig_t digest_q [$];
	sha1md_pkg::dig_t want;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, exp_val);
		fail_count++;
	endtask

	function automatic void restart_digest();
		chain_h[0] = sha1md_pkg::H_INIT0;
		chain_h[1] = sha1md_pkg::H_INIT1;
		chain_h[2] = sha1md_pkg::H_INIT2;
		chain_h[3] = sha1md_pkg::H_INIT3;
		chain_h[4] = sha1md_pkg::H_INIT4;
		msg_bits = '0;
		fill = 0;
	endfunction

	function automatic void sha1_compress();
		logic [31:0] a, b, c, d, e, w, f, k, t;
		a = chain_h[0];
		b = chain_h[1];
		c = chain_h[2];
		d = chain_h[3];
		e = chain_h[4];
		for (int r = 0; r < 80; r++) begin
			if (r < 16) begin
				w = sched_w[r];
			end else begin
				w = sched_w[(r - 3) & 15] ^ sched_w[(r - 8) & 15]
					^ sched_w[(r - 14) & 15] ^ sched_w[r & 15];
				w = {w[30:0], w[31]};
				sched_w[r & 15] = w;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = sha1md_pkg::K_R0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = sha1md_pkg::K_R1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = sha1md_pkg::K_R2;
			end else begin
				f = b ^ c ^ d;
				k = sha1md_pkg::K_R3;
			end
			t = {a[26:0], a[31:27]} + f + e + w + k;
			e = d;
			d = c;
			c = {b[1:0], b[31:2]};
			b = a;
			a = t;
		end
		chain_h[0] = chain_h[0] + a;
		chain_h[1] = chain_h[1] + b;
		chain_h[2] = chain_h[2] + c;
		chain_h[3] = chain_h[3] + d;
		chain_h[4] = chain_h[4] + e;
	endfunction

	function automatic void load_byte(input logic [7:0] b);
		logic [31:0] word;
		word = (fill % 4 == 0) ? 32'h0 : sched_w[fill / 4];
		word = word | ({24'h0, b} << (8 * (3 - fill % 4)));
		sched_w[fill / 4] = word;
		fill++;
		if (fill == 64) begin
			sha1_compress();
			fill = 0;
		end
	endfunction

	function automatic void pad_and_emit();
		logic [63:0]      len;
		sha1md_pkg::dig_t res;
		len = msg_bits;
		load_byte(sha1md_pkg::PAD_MARK);
		if (fill > 56) begin
			while (fill != 0)
				load_byte(8'h00);
		end
		while (fill < 56)
			load_byte(8'h00);
		for (int i = 7; i >= 0; i--)
			load_byte(len[8 * i +: 8]);
		for (int i = 0; i < 5; i++) begin
			res.digest_word = chain_h[i];
			res.word_number = 3'(i);
			res.last_word = (i == 4);
			digest_q.push_back(res);
		end
		restart_digest();
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			restart_digest();
			digest_q.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (dig_valid && dig_ready) begin
				if (digest_q.size() == 0) begin
					report_mismatch("unexpected digest word", dig.digest_word, 32'h0);
				end else begin
					want = digest_q.pop_front();
					if (dig.digest_word !== want.digest_word)
						report_mismatch("digest_word", dig.digest_word, want.digest_word);
					if (dig.word_number !== want.word_number)
						report_mismatch("word_number", 32'(dig.word_number),
							32'(want.word_number));
					if (dig.last_word !== want.last_word)
						report_mismatch("last_word", 32'(dig.last_word), 32'(want.last_word));
				end
			end
			if (msg_valid && msg_ready) begin
				if (msg.byte_present) begin
					// saturate the bit count at the length field limit
					if (msg_bits > sha1md_pkg::COUNT_LIMIT - 64'd8)
						msg_bits = sha1md_pkg::COUNT_LIMIT;
					else
						msg_bits = msg_bits + 64'd8;
					load_byte(msg.data_byte);
				end
				if (msg.end_of_message)
					pad_and_emit();
			end
			pending <= digest_q.size();
		end
	end

endmodule

FILE: tb/tb_sha1_message_digest_top.sv
`timescale 1ns / 100ps
//------------------------------------------------------------------------------
// SHA-1 message digest testbench
// Sends directed messages (empty, single bytes, a short text) and then random
// messages of mixed lengths around the padding boundaries, with idle gaps and
// ignored words on the message side and random stalls on the digest side.
// A separate checker predicts and compares every digest word.
//------------------------------------------------------------------------------

module tb_sha1_message_digest_top;

	localparam int ITEM_TARGET  = 280;
	localparam int MIN_MESSAGES = 12;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 400000;

	logic clk;
	logic arst_n;
	logic msg_valid;
	logic msg_ready;
	sha1md_pkg::msg_t msg;
	logic dig_valid;
	logic dig_ready;
	sha1md_pkg::dig_t dig;

	int   fail_count;
	int   pending;
	int   items_sent;
	int   messages_done;
	int   cycle_count;
	int   stall_left;
	int   len;
	bit   calm_send;
	bit   calm_recv;
	logic [7:0] payload_q [$];

	sha1_message_digest_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_ready (msg_ready),
		.msg       (msg),
		.dig_valid (dig_valid),
		.dig_ready (dig_ready),
		.dig       (dig)
	);

	sha1_digest_checker digest_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.msg_valid  (msg_valid),
		.msg_ready  (msg_ready),
		.msg        (msg),
		.dig_valid  (dig_valid),
		.dig_ready  (dig_ready),
		.dig        (dig),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic send_word(input sha1md_pkg::msg_t w);
		int gap;
		gap = pick_gap(calm_send);
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg_valid <= 1'b1;
		msg <= w;
		do @(posedge clk); while (!msg_ready);
		if (w.byte_present || w.end_of_message)
			items_sent++;
	endtask

	// end the message on its last byte, or with a separate end word
	task automatic send_message(input bit end_alone);
		sha1md_pkg::msg_t w;
		for (int i = 0; i < payload_q.size(); i++) begin
			if ($urandom_range(0, 15) == 0) begin
				w.data_byte = 8'($urandom);
				w.byte_present = 1'b0;
				w.end_of_message = 1'b0;
				send_word(w);
			end
			w.data_byte = payload_q[i];
			w.byte_present = 1'b1;
			w.end_of_message = !end_alone && (i == payload_q.size() - 1);
			send_word(w);
		end
		if (end_alone || payload_q.size() == 0) begin
			w.data_byte = 8'($urandom);
			w.byte_present = 1'b0;
			w.end_of_message = 1'b1;
			send_word(w);
		end
		payload_q.delete();
		messages_done++;
	endtask

	initial begin
		dig_ready = 1'b0;
		stall_left = 0;
		calm_recv = 1'b0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0)
				calm_recv = !calm_recv;
			if (stall_left > 0) begin
				dig_ready <= 1'b0;
				stall_left--;
			end else begin
				dig_ready <= 1'b1;
				if (!calm_recv && $urandom_range(0, 3) == 0)
					stall_left = pick_gap(1'b0);
			end
		end
	end

	initial begin
		msg_valid = 1'b0;
		msg = '0;
		arst_n = 1'b0;
		cycle_count = 0;
		items_sent = 0;
		messages_done = 0;
		calm_send = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_message(1'b1);
		send_word('{data_byte: 8'hA5, byte_present: 1'b0, end_of_message: 1'b0});
		payload_q.push_back(8'h00);
		send_message(1'b0);
		payload_q.push_back(8'hFF);
		send_message(1'b1);
		payload_q.push_back(8'h61);
		payload_q.push_back(8'h62);
		payload_q.push_back(8'h63);
		send_message(1'b0);
		payload_q.push_back(8'h80);
		payload_q.push_back(8'h7F);
		send_message(1'b1);

		while (items_sent < ITEM_TARGET || messages_done < MIN_MESSAGES) begin
			calm_send = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 4) == 0) begin
				case ($urandom_range(0, 7))
					0: len = 55;
					1: len = 56;
					2: len = 57;
					3: len = 63;
					4: len = 64;
					5: len = 65;
					6: len = 119;
					default: len = 128;
				endcase
			end else begin
				len = $urandom_range(0, 12);
			end
			repeat (len) payload_q.push_back(8'($urandom));
			send_message(1'($urandom_range(0, 1)));
		end
		msg_valid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
